// File: hdl/ccm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared types, register indexes and helpers for the color correction matrix.
// ----------------------------------------------------------------------------
package ccm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int ROW_W    = 3 * COEF_W;
   localparam int DEPTH_W  = 5;
   localparam int INDEX_W  = 3;
   localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
   localparam int SUM_W    = PROD_W + 2;

   localparam logic [INDEX_W-1:0] REG_ENABLE    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_DEPTH     = 3'd1;
   localparam logic [INDEX_W-1:0] REG_ROW_RED   = 3'd2;
   localparam logic [INDEX_W-1:0] REG_ROW_GREEN = 3'd3;
   localparam logic [INDEX_W-1:0] REG_ROW_BLUE  = 3'd4;

   localparam logic [ROW_W-1:0]   ROW_RED_RST   = 48'h0400_0000_0000;
   localparam logic [ROW_W-1:0]   ROW_GREEN_RST = 48'h0000_0400_0000;
   localparam logic [ROW_W-1:0]   ROW_BLUE_RST  = 48'h0000_0000_0400;
   localparam logic [DEPTH_W-1:0] DEPTH_RST     = 5'd12;

   typedef struct packed {
      logic                enable;
      logic [SAMPLE_W-1:0] maxval;
   } ccm_cfg_type;

   // depth 0 acts as 1, anything above 16 acts as 16
   function automatic logic [SAMPLE_W-1:0] depth_max(input logic [DEPTH_W-1:0] depth);
      logic [DEPTH_W-1:0] d;
      d = depth;
      if (depth == 5'd0) begin
         d = 5'd1;
      end else if (depth > 5'd16) begin
         d = 5'd16;
      end
      return SAMPLE_W'((17'(1) << d) - 17'(1));
   endfunction

endpackage
`default_nettype wire

// File: hdl/ccm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_if
// Pixel in, pixel out and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccm_pix_in_if;
   logic        valid;
   logic        ready;
   logic [15:0] red_in;
   logic [15:0] green_in;
   logic [15:0] blue_in;
   logic        last_in;

   modport source (output valid, red_in, green_in, blue_in, last_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, last_in, output ready);
endinterface

interface ccm_pix_out_if;
   logic        valid;
   logic        ready;
   logic [15:0] red_out;
   logic [15:0] green_out;
   logic [15:0] blue_out;
   logic        last_out;

   modport source (output valid, red_out, green_out, blue_out, last_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, last_out, output ready);
endinterface

interface ccm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/ccm_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_row
// One output channel: three products, rounded sum, clamp or pass-through.
// ----------------------------------------------------------------------------
module ccm_row #(
   parameter int COEF_FRAC_BITS = 10
) (
   input  wire logic                          clock,
   input  wire logic                          adv,
   input  wire logic [ccm_pkg::ROW_W-1:0]     coef_row,
   input  wire logic [ccm_pkg::SAMPLE_W-1:0]  red,
   input  wire logic [ccm_pkg::SAMPLE_W-1:0]  green,
   input  wire logic [ccm_pkg::SAMPLE_W-1:0]  blue,
   input  wire logic [ccm_pkg::SAMPLE_W-1:0]  pass,
   input  wire ccm_pkg::ccm_cfg_type          cfg,
   output logic      [ccm_pkg::SAMPLE_W-1:0]  result
);
   import ccm_pkg::*;

   localparam logic signed [SUM_W-1:0] Round = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);

   logic signed [COEF_W-1:0] c_r, c_g, c_b;
   logic signed [PROD_W-1:0] prod_r_in, prod_g_in, prod_b_in;
   logic signed [PROD_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic signed [SUM_W-1:0]  sum_in, sum_ff;
   logic [SUM_W-1:0]         shifted;
   logic [SAMPLE_W-1:0]      pass1_ff, pass2_ff;
   logic [SAMPLE_W-1:0]      result_in, result_ff;

   // stage 1: products
   always_comb begin
      c_r = $signed(coef_row[47:32]);
      c_g = $signed(coef_row[31:16]);
      c_b = $signed(coef_row[15:0]);
      prod_r_in = PROD_W'(c_r) * $signed({1'b0, red});
      prod_g_in = PROD_W'(c_g) * $signed({1'b0, green});
      prod_b_in = PROD_W'(c_b) * $signed({1'b0, blue});
   end

   // stage 2: sum plus half lsb
   assign sum_in = SUM_W'(prod_r_ff) + SUM_W'(prod_g_ff) + SUM_W'(prod_b_ff) + Round;

   // stage 3: floor, clamp low at zero and high at depth max, or pass-through when disabled
   always_comb begin
      shifted = $unsigned(sum_ff) >> COEF_FRAC_BITS;
      if (!cfg.enable) begin
         result_in = pass2_ff;
      end else if (sum_ff[SUM_W-1]) begin
         result_in = '0;
      end else if (shifted > SUM_W'(cfg.maxval)) begin
         result_in = cfg.maxval;
      end else begin
         result_in = SAMPLE_W'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_r_ff <= prod_r_in;
         prod_g_ff <= prod_g_in;
         prod_b_ff <= prod_b_in;
         pass1_ff  <= pass;
         sum_ff    <= sum_in;
         pass2_ff  <= pass1_ff;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire

// File: hdl/color_correction_matrix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// color_correction_matrix
// 3x3 color correction of an RGB pixel stream with round and depth clamp.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and passes it through products, rounded sum and
// clamp. The three-stage multiply/add/clamp pipeline registers each step;
// a stall on rsp freezes every stage together, so throughput is one
// pixel per clock whenever rsp is ready. Coefficients are signed 16-bit with
// COEF_FRAC_BITS fraction bits. Registers are written through csr (always
// ready) and must only change while no pixels are in flight.
module color_correction_matrix #(
   parameter int COEF_FRAC_BITS = 10
) (
   input  wire logic     clock,
   input  wire logic     reset,
   ccm_pix_in_if.sink    req,
   ccm_pix_out_if.source rsp,
   ccm_csr_if.sink       csr
);
   import ccm_pkg::*;

   logic               enable_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [ROW_W-1:0]   row_red_ff, row_green_ff, row_blue_ff;
   ccm_cfg_type        cfg;
   logic               adv;
   logic               v1_ff, v2_ff, v3_ff;
   logic               last1_ff, last2_ff, last3_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         depth_ff     <= DEPTH_RST;
         row_red_ff   <= ROW_RED_RST;
         row_green_ff <= ROW_GREEN_RST;
         row_blue_ff  <= ROW_BLUE_RST;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_ENABLE:    enable_ff    <= csr.data[0];
            REG_DEPTH:     depth_ff     <= csr.data[DEPTH_W-1:0];
            REG_ROW_RED:   row_red_ff   <= csr.data;
            REG_ROW_GREEN: row_green_ff <= csr.data;
            REG_ROW_BLUE:  row_blue_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   assign cfg.enable = enable_ff;
   assign cfg.maxval = depth_max(depth_ff);

   assign adv       = !v3_ff || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last1_ff <= req.last_in;
         last2_ff <= last1_ff;
         last3_ff <= last2_ff;
      end
   end

   ccm_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_red (
      .clock(clock), .adv(adv), .coef_row(row_red_ff),
      .red(req.red_in), .green(req.green_in), .blue(req.blue_in),
      .pass(req.red_in), .cfg(cfg), .result(rsp.red_out)
   );

   ccm_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_green (
      .clock(clock), .adv(adv), .coef_row(row_green_ff),
      .red(req.red_in), .green(req.green_in), .blue(req.blue_in),
      .pass(req.green_in), .cfg(cfg), .result(rsp.green_out)
   );

   ccm_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_blue (
      .clock(clock), .adv(adv), .coef_row(row_blue_ff),
      .red(req.red_in), .green(req.green_in), .blue(req.blue_in),
      .pass(req.blue_in), .cfg(cfg), .result(rsp.blue_out)
   );

   assign rsp.valid    = v3_ff;
   assign rsp.last_out = last3_ff;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!v1_ff && !v2_ff && !v3_ff))
      else $error("pipeline valid bits not cleared by reset");

   a_beat_enters: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> v1_ff)
      else $error("accepted beat missing from first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rsp.ready) |=> (v3_ff && $stable(v2_ff) && $stable(v1_ff)))
      else $error("pipeline moved during output stall");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $rose(v3_ff) |-> $past(v2_ff))
      else $error("output beat without a beat in stage two");
`endif

endmodule
`default_nettype wire
